/* rtl/pfx_pkg.sv */
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared constants for the postfix expression evaluator: stack geometry,
// character codes of the operators and the result status codes.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned STACK_CW    = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] SYM_ZERO = 8'h30;  // '0'
  localparam logic [7:0] SYM_ADD  = 8'h2B;  // '+'
  localparam logic [7:0] SYM_SUB  = 8'h2D;  // '-'
  localparam logic [7:0] SYM_MUL  = 8'h2A;  // '*'
  localparam logic [7:0] SYM_DIV  = 8'h2F;  // '/'

  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_UNDER = 3'd1;
  localparam logic [2:0] STAT_OVER  = 3'd2;
  localparam logic [2:0] STAT_DIV0  = 3'd3;
  localparam logic [2:0] STAT_EMPTY = 3'd4;

endpackage

/* rtl/pfx_in_if.sv */
// ----------------------------------------------------------------------------
// pfx_in_if / pfx_out_if
// Valid/ready channels of the evaluator: character words in, result words out.
// ----------------------------------------------------------------------------
interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [2:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

/* rtl/postfix_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix expressions one character word at a time on a stack
// held in a synchronous memory.
//
//   channel | dir | words                 | handshake
//   in_i    | in  | symbol[7:0], last     | valid/ready
//   out_o   | out | value[31:0], status   | valid/ready, one word per last
//
// The bit-serial divider runs 32 steps for '/', but not when the divisor
// is zero. Every character starts with a two-address read of the stack
// memory, whose read data is registered. Reset clears the stack count, the
// error record and the output register; memory contents need no clearing
// since only entries below the count are read. A result waiting on out_o does
// not block the next character; only a last character stalls until the
// output register frees.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
  import pfx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  pfx_in_if.sink   in_i,
  pfx_out_if.source out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_PUSH
  } state_e;

  // stack memory: one write port, two registered read ports
  logic [DATA_W-1:0] stack_q [STACK_DEPTH];
  logic [DATA_W-1:0] rd_b_q, rd_a_q;
  logic [STACK_AW-1:0] raddr_b, raddr_a;
  logic                mem_we;
  logic [STACK_AW-1:0] mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;

  state_e              state_q, state_d;
  logic [STACK_CW-1:0] cnt_q, cnt_d;
  logic [2:0]          err_q, err_d;
  logic [7:0]          sym_q, sym_d;
  logic                last_q, last_d;
  logic [DATA_W-1:0]   res_q, res_d;
  logic                neg_q, neg_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_value_q, out_value_d;
  logic [2:0]          out_status_q, out_status_d;

  logic                in_acc;
  logic                is_op;
  logic                have_a, have_b;
  logic [DATA_W-1:0]   op_a, op_b;
  logic [STACK_CW-1:0] cnt_pop;
  logic                div_zero;
  logic [DATA_W-1:0]   operand_val;
  logic                finish_stall;

  logic                fin_go;
  logic [STACK_CW-1:0] fin_cnt;
  logic [2:0]          fin_err;
  logic [DATA_W-1:0]   fin_top;
  logic                emit;

  logic                div_start;
  logic                div_done;
  logic [DATA_W-1:0]   div_quo;
  logic [DATA_W-1:0]   mag_a, mag_b;

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // read the two top entries of the stack when a character arrives
  assign raddr_b = (cnt_q >= STACK_CW'(1)) ? STACK_AW'(cnt_q - STACK_CW'(1)) : '0;
  assign raddr_a = (cnt_q >= STACK_CW'(2)) ? STACK_AW'(cnt_q - STACK_CW'(2)) : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_b_q <= stack_q[raddr_b];
      rd_a_q <= stack_q[raddr_a];
    end
    if (mem_we) begin
      stack_q[mem_waddr] <= mem_wdata;
    end
  end

  // pops of an empty stack yield all ones
  assign is_op  = (sym_q inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV});
  assign have_b = (cnt_q >= STACK_CW'(1));
  assign have_a = (cnt_q >= STACK_CW'(2));
  assign op_b   = have_b ? rd_b_q : '1;
  assign op_a   = have_a ? rd_a_q : '1;
  assign cnt_pop  = have_a ? (cnt_q - STACK_CW'(2)) : '0;
  assign div_zero = (sym_q == SYM_DIV) && (op_b == '0);
  assign operand_val = {{(DATA_W-8){1'b0}}, sym_q} - DATA_W'(SYM_ZERO);

  // magnitudes for the divider; the sign is restored on the quotient
  assign mag_a = op_a[DATA_W-1] ? (DATA_W'(0) - op_a) : op_a;
  assign mag_b = op_b[DATA_W-1] ? (DATA_W'(0) - op_b) : op_b;

  // a last character needs the output register free before it retires
  assign finish_stall = last_q && out_valid_q && !out_o.ready;

  pfx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_a),
    .divisor_i  (mag_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    sym_d        = sym_q;
    last_d       = last_q;
    res_d        = res_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[STACK_AW-1:0];
    mem_wdata    = res_q;
    div_start    = 1'b0;
    fin_go       = 1'b0;
    fin_cnt      = cnt_q;
    fin_err      = err_q;
    fin_top      = res_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sym_d   = in_i.symbol;
          last_d  = in_i.last;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (is_op) begin
          cnt_d = cnt_pop;
          // first error wins: underflow precedes divide by zero
          if (err_q == STAT_OK) begin
            if (!have_a) begin
              err_d = STAT_UNDER;
            end else if (div_zero) begin
              err_d = STAT_DIV0;
            end
          end
          state_d = S_PUSH;
          case (sym_q)
            SYM_ADD: res_d = op_a + op_b;
            SYM_SUB: res_d = op_a - op_b;
            SYM_MUL: res_d = op_a * op_b;
            SYM_DIV: begin
              if (div_zero) begin
                res_d = '0;
              end else begin
                div_start = 1'b1;
                neg_d     = op_a[DATA_W-1] ^ op_b[DATA_W-1];
                state_d   = S_DIV;
              end
            end
            default: res_d = res_q;
          endcase
        end else if (!finish_stall) begin
          fin_go = 1'b1;
          if (cnt_q < STACK_CW'(STACK_DEPTH)) begin
            mem_we    = 1'b1;
            mem_wdata = operand_val;
            fin_cnt   = cnt_q + STACK_CW'(1);
            fin_top   = operand_val;
          end else begin
            // full: drop the push, top stays the last entry
            fin_err = (err_q == STAT_OK) ? STAT_OVER : err_q;
            fin_top = rd_b_q;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = neg_q ? (DATA_W'(0) - div_quo) : div_quo;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        // after two pops there is always room for the result
        if (!finish_stall) begin
          mem_we  = 1'b1;
          fin_go  = 1'b1;
          fin_cnt = cnt_q + STACK_CW'(1);
          fin_top = res_q;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin_go) begin
      state_d = S_IDLE;
      if (last_q) begin
        out_valid_d = 1'b1;
        out_value_d = (fin_cnt == '0) ? '1 : fin_top;
        if (fin_err != STAT_OK) begin
          out_status_d = fin_err;
        end else begin
          out_status_d = (fin_cnt == '0) ? STAT_EMPTY : STAT_OK;
        end
        cnt_d = '0;
        err_d = STAT_OK;
      end else begin
        cnt_d = fin_cnt;
        err_d = fin_err;
      end
    end
  end

  assign emit = fin_go && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      err_q        <= STAT_OK;
      sym_q        <= '0;
      last_q       <= 1'b0;
      res_q        <= '0;
      neg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= STAT_OK;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      err_q        <= err_d;
      sym_q        <= sym_d;
      last_q       <= last_d;
      res_q        <= res_d;
      neg_q        <= neg_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

  // hold the count within the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= STACK_CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // drop the stack after a result is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (cnt_q == '0) && (err_q == STAT_OK) && out_valid_q)
    else $error("stack not cleared after result");

  // keep the first error until the expression ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != STAT_OK) && !emit |=> err_q == $past(err_q))
    else $error("first error overwritten");

  // the divider may finish only while in the divide state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");

endmodule

/* rtl/pfx_div.sv */
// ----------------------------------------------------------------------------
// pfx_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfx_div
  import pfx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DATA_W);

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  step_q;
  logic [DATA_W:0]   rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dvs_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  assign shifted = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        // subtract when it fits, otherwise keep the shifted remainder
        if (!diff[DATA_W+1]) begin
          rem_q <= diff[DATA_W:0];
          quo_q <= {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted;
          quo_q <= {quo_q[DATA_W-2:0], 1'b0};
        end
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for postfix_expression_evaluator. A short table of
// character words comes first, then random expressions that are mostly well
// formed, with noise mixed in. A behavioral stack predicts every result word
// that the table does not give. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import pfx_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The
  // slowest word is a divide behind a full output register.
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_WORDS = 1000;
  // The last words of the run go through with no idling on either side.
  localparam int unsigned QUIET_WORDS  = 150;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [2:0]  status;
  } result_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       typed;  // use res below instead of the predictor
    result_t    res;
  } char_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pfx_in_if  sym_ch ();
  pfx_out_if res_ch ();

  postfix_expression_evaluator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (sym_ch),
    .out_o  (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stack predictor: its own copy of the stack, the occupancy and the first
  // error of the expression in progress.
  // --------------------------------------------------------------------------
  logic [31:0] calc_stack [STACK_DEPTH];
  int unsigned calc_depth;
  logic [2:0]  calc_fault;

  result_t     pending_results [$];
  int unsigned fail_count;

  // Shared between the word driver and the monitor.
  bit          quiet;
  int unsigned gap_pct;
  bit          row_typed;
  result_t     row_res;
  int unsigned n_sent;

  // Keep only the first error of an expression.
  function automatic void note_fault(input logic [2:0] code);
    if (calc_fault == STAT_OK) calc_fault = code;
  endfunction

  // Drop the value when the stack is full.
  function automatic void calc_push(input logic [31:0] v);
    if (calc_depth >= STACK_DEPTH) begin
      note_fault(STAT_OVER);
    end else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endfunction

  // An empty stack yields all ones (-1).
  function automatic logic [31:0] calc_pop();
    if (calc_depth == 0) begin
      note_fault(STAT_UNDER);
      return '1;
    end
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  // Divide magnitudes, then restore the sign: truncates toward zero and lets
  // the most negative value over -1 wrap back to itself.
  function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic bit is_operator(input logic [7:0] sym);
    return sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL || sym == SYM_DIV;
  endfunction

  // Advance the predictor by one character word; return 1 with the result
  // word when the character closes the expression.
  function automatic bit eval_char(input logic [7:0] sym, input logic lst,
                                   output result_t r);
    logic [31:0] a, b, y;
    r = '0;
    y = '0;
    if (is_operator(sym)) begin
      b = calc_pop();
      a = calc_pop();
      case (sym)
        SYM_ADD: y = a + b;
        SYM_SUB: y = a - b;
        SYM_MUL: y = a * b;
        default: begin
          if (b == '0) begin
            note_fault(STAT_DIV0);
            y = '0;
          end else begin
            y = quot_trunc(a, b);
          end
        end
      endcase
      calc_push(y);
    end else begin
      // Any other byte is an operand worth its code minus '0'.
      calc_push({24'd0, sym} - {24'd0, SYM_ZERO});
    end
    if (!lst) return 1'b0;
    if (calc_depth == 0) begin
      r.value  = '1;
      r.status = (calc_fault != STAT_OK) ? calc_fault : STAT_EMPTY;
    end else begin
      r.value  = calc_stack[calc_depth - 1];
      r.status = calc_fault;
    end
    calc_depth = 0;
    calc_fault = STAT_OK;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check result words first, then feed accepted character words to
  // the predictor. A result can never belong to a word accepted on the same
  // edge, so the order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want, pred;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: value %0d status %0d",
                 $signed(res_ch.value), res_ch.status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (res_ch.value !== want.value) begin
            $error("value: expected %0d, actual %0d", $signed(want.value),
                   $signed(res_ch.value));
            fail_count++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            fail_count++;
          end
        end
      end
      if (sym_ch.valid && sym_ch.ready) begin
        if (eval_char(sym_ch.symbol, sym_ch.last, pred))
          pending_results.push_back(row_typed ? row_res : pred);
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: hold ready low in random bursts. The stall rate is redrawn
  // among 0, 20 and 50 percent, so some stretches run with no stalls at all.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;
  int unsigned rate_cycle = 0;
  always @(negedge clk) begin
    rate_cycle++;
    if (rate_cycle % 128 == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        default: stall_pct = 50;
      endcase
    end
    if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      res_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Character side
  // --------------------------------------------------------------------------

  // Drive one word at the falling edge, after an optional idle burst, and
  // hold it until accepted. Valid stays high when the next word follows
  // directly.
  task automatic send_char(input logic [7:0] sym, input logic lst,
                           input bit typed, input result_t res);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      @(negedge clk);
      sym_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= sym;
    sym_ch.last   <= lst;
    row_typed = typed;
    row_res   = res;
    do @(posedge clk); while (!sym_ch.ready);
    n_sent++;
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return SYM_ADD;
      1:       return SYM_SUB;
      2:       return SYM_MUL;
      default: return SYM_DIV;
    endcase
  endfunction

  // Mostly decimal digits (zero often enough to divide by it), sometimes any
  // other non-operator byte.
  function automatic logic [7:0] pick_operand();
    logic [7:0] s;
    if ($urandom_range(0, 3) != 0) return SYM_ZERO + 8'($urandom_range(0, 9));
    do s = 8'($urandom); while (is_operator(s));
    return s;
  endfunction

  // Send a well-formed expression of n_opnd operands with random operators;
  // the last flag rides on the word that leaves exactly one value.
  task automatic send_expression(input int unsigned n_opnd);
    int unsigned pushed, depth;
    logic [7:0]  sym;
    pushed = 0;
    depth  = 0;
    while (!(pushed == n_opnd && depth == 1)) begin
      if (pushed < n_opnd && (depth < 2 || $urandom_range(0, 2) != 0)) begin
        sym = pick_operand();
        pushed++;
        depth++;
      end else begin
        sym = pick_operator();
        depth--;
      end
      send_char(sym, pushed == n_opnd && depth == 1, 1'b0, '0);
    end
  endtask

  function automatic char_row_t mk_row(input logic [7:0] sym, input logic lst,
                                       input logic typed, input logic signed [31:0] val,
                                       input logic [2:0] st);
    char_row_t r;
    r.symbol     = sym;
    r.last       = lst;
    r.typed      = typed;
    r.res.value  = val;
    r.res.status = st;
    return r;
  endfunction

  initial begin
    char_row_t   rows [$];
    int unsigned n_dir, len;
    sym_ch.valid  = 1'b0;
    sym_ch.symbol = '0;
    sym_ch.last   = 1'b0;
    calc_depth    = 0;
    calc_fault    = STAT_OK;
    fail_count    = 0;
    quiet         = 1'b0;
    gap_pct       = 25;
    row_typed     = 1'b0;
    row_res       = '0;
    n_sent        = 0;

    // Single operand closes at once.
    rows.push_back(mk_row(SYM_ZERO + 8'd5, 1'b1, 1'b1, 32'sd5, STAT_OK));
    // Operator on an empty stack: both pops give -1, the sum is -2.
    rows.push_back(mk_row(SYM_ADD, 1'b1, 1'b1, -32'sd2, STAT_UNDER));
    // Extremes of the byte as operands.
    rows.push_back(mk_row(8'h00, 1'b1, 1'b1, -32'sd48, STAT_OK));
    rows.push_back(mk_row(8'hFF, 1'b1, 1'b1, 32'sd207, STAT_OK));
    // 3 - 9 = -6, then -6 / 4 truncates to -1.
    rows.push_back(mk_row(SYM_ZERO + 8'd3, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_ZERO + 8'd9, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_SUB, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_ZERO + 8'd4, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_DIV, 1'b1, 1'b0, '0, STAT_OK));
    // Divide by zero pushes 0.
    rows.push_back(mk_row(SYM_ZERO + 8'd9, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_ZERO, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_DIV, 1'b1, 1'b1, 32'sd0, STAT_DIV0));
    // Byte B0 is 128: 128^4 * 8 wraps to the most negative value, which is
    // then divided by 0 - 1 and must wrap back to itself.
    rows.push_back(mk_row(8'hB0, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(8'hB0, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_MUL, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(8'hB0, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_MUL, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(8'hB0, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_MUL, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_ZERO + 8'd8, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_MUL, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_ZERO, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_ZERO + 8'd1, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_SUB, 1'b0, 1'b0, '0, STAT_OK));
    rows.push_back(mk_row(SYM_DIV, 1'b1, 1'b1, 32'sh8000_0000, STAT_OK));
    n_dir = rows.size();

    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the table.
    foreach (rows[i]) send_char(rows[i].symbol, rows[i].last, rows[i].typed, rows[i].res);

    // Random part: mostly well-formed expressions, some deep enough to
    // overflow, the rest noise heavy in operators to reach underflow and
    // repeated errors in one expression.
    while (n_sent < n_dir + RANDOM_WORDS) begin
      quiet = (n_sent + QUIET_WORDS >= n_dir + RANDOM_WORDS);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 20;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 6);
          repeat (len)
            send_char($urandom_range(0, 1) ? pick_operator() : 8'($urandom),
                      $urandom_range(0, 2) == 0, 1'b0, '0);
        end
        1:       send_expression($urandom_range(15, 20));
        default: send_expression($urandom_range(1, 6));
      endcase
    end

    // Drop valid, drain every expected word, then let the divider settle.
    @(negedge clk);
    sym_ch.valid <= 1'b0;
    row_typed = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
